// ===== hw/rtl/sldf_pkg.sv =====
package sldf_pkg;

    // framing bytes and lengths
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE  = 8'hFE;
    localparam logic [7:0] LEN_D     = 8'd21;
    localparam logic [7:0] LEN_S     = 8'd18;
    localparam logic [7:0] TYPE_D    = 8'h44;
    localparam logic [7:0] TYPE_S    = 8'h53;

    // index of the final payload byte for each frame kind
    localparam logic [3:0] LAST_IDX_D = 4'd15;
    localparam logic [3:0] LAST_IDX_S = 4'd12;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OC_PAYLOAD  = 2'd0,
        OC_BAD_SUM  = 2'd1,
        OC_MISMATCH = 2'd2
    } outcome_t;

    // one finished frame waiting for the back end
    typedef struct packed {
        outcome_t   outcome;
        logic       kind;
        logic [3:0] last_idx;
    } frame_desc_t;

    // payload write from the front end into the buffer banks
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [3:0] idx;
        logic [7:0] data;
    } pay_wr_t;

endpackage

// ===== hw/rtl/sync_length_checksum_deframer.sv =====
// Deframer for a serial link: one received byte per input word.
// Input channel: in_valid / in_ready with rx_byte. The block hunts for the
// sync byte 0xFF, takes a length byte (21 or 18), then type, payload,
// checksum and end byte 0xFE.
// Output channel: out_valid / out_ready with outcome, frame_kind, byte_index,
// payload_byte and last. A good frame gives 16 ('D') or 13 ('S') payload
// words, the final one with last set; a bad frame gives one reject word.
// Throughput: one input byte per cycle while in_ready is high, one output word per cycle while out_ready is high.
// The first word of a frame is presented after the end byte is accepted:
// the queue takes the frame on the accepting edge, then the registered buffer
// read loads the output word once the output register is free or being taken.
// Finished frames wait in a two-entry queue, each entry owning one payload
// bank; in_ready drops only while both entries are occupied, so a stalled
// receiver holds the input back once two frames are pending.
// Reset empties the queue, clears the output valid and restarts the hunt;
// the payload banks are not cleared.
module sync_length_checksum_deframer
#(
    parameter int PAYLOAD_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] outcome,
    output logic       frame_kind,
    output logic [3:0] byte_index,
    output logic [7:0] payload_byte,
    output logic       last
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    logic                  wr_ptr;
    logic                  rd_ptr;
    sldf_pkg::frame_desc_t push_desc;
    sldf_pkg::frame_desc_t head;
    sldf_pkg::pay_wr_t     pay_wr;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    // parser front end
    sldf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .wr_bank   (wr_ptr),
        .push      (push),
        .push_desc (push_desc),
        .pay_wr    (pay_wr)
    );

    // frame queue
    sldf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .wr_ptr    (wr_ptr),
        .rd_ptr    (rd_ptr),
        .head      (head)
    );

    // payload buffer and output stage
    sldf_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pay_wr       (pay_wr),
        .empty        (empty),
        .rd_ptr       (rd_ptr),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .outcome      (outcome),
        .frame_kind   (frame_kind),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule

// ===== hw/rtl/sldf_front.sv =====
module sldf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                wr_bank,
    output logic                push,
    output sldf_pkg::frame_desc_t push_desc,
    output sldf_pkg::pay_wr_t   pay_wr
);

    sldf_pkg::phase_t phase_reg, phase_next;
    logic [4:0] bytes_seen_reg, bytes_seen_next;
    logic [4:0] frame_length_reg, frame_length_next;
    logic [7:0] type_byte_reg, type_byte_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] received_check_reg, received_check_next;

    logic [5:0] pos_plus2;
    logic [5:0] len_ext;
    logic [4:0] pay_pos;
    logic       sum_ok;
    logic       len_is_s;
    logic       type_match;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= sldf_pkg::PH_HUNT;
            bytes_seen_reg     <= '0;
            frame_length_reg   <= '0;
            type_byte_reg      <= '0;
            running_sum_reg    <= '0;
            received_check_reg <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            bytes_seen_reg     <= bytes_seen_next;
            frame_length_reg   <= frame_length_next;
            type_byte_reg      <= type_byte_next;
            running_sum_reg    <= running_sum_next;
            received_check_reg <= received_check_next;
        end
    end

    // position compares within the frame
    assign pos_plus2 = {1'b0, bytes_seen_reg} + 6'd2;
    assign len_ext   = {1'b0, frame_length_reg};
    assign pay_pos   = bytes_seen_reg - 5'd3;
    assign len_is_s  = (frame_length_reg == sldf_pkg::LEN_S[4:0]);
    assign sum_ok    = (rx_byte == sldf_pkg::END_BYTE) &&
                       (running_sum_reg == received_check_reg);
    assign type_match = ((type_byte_reg == sldf_pkg::TYPE_D) &&
                         (frame_length_reg == sldf_pkg::LEN_D[4:0])) ||
                        ((type_byte_reg == sldf_pkg::TYPE_S) && len_is_s);

    // next state and frame classification
    always_comb
    begin
        phase_next          = phase_reg;
        bytes_seen_next     = bytes_seen_reg;
        frame_length_next   = frame_length_reg;
        type_byte_next      = type_byte_reg;
        running_sum_next    = running_sum_reg;
        received_check_next = received_check_reg;
        push                = 1'b0;
        push_desc.outcome   = sldf_pkg::OC_PAYLOAD;
        push_desc.kind      = len_is_s;
        push_desc.last_idx  = len_is_s ? sldf_pkg::LAST_IDX_S : sldf_pkg::LAST_IDX_D;
        pay_wr.en           = 1'b0;
        pay_wr.bank         = wr_bank;
        pay_wr.idx          = pay_pos[3:0];
        pay_wr.data         = rx_byte;

        if (accept)
        begin
            case (phase_reg)
                sldf_pkg::PH_SYNC:
                begin
                    if (rx_byte == sldf_pkg::LEN_D || rx_byte == sldf_pkg::LEN_S)
                    begin
                        frame_length_next = rx_byte[4:0];
                        running_sum_next  = rx_byte;
                        bytes_seen_next   = 5'd2;
                        phase_next        = sldf_pkg::PH_COLLECT;
                    end
                    else if (rx_byte != sldf_pkg::SYNC_BYTE)
                    begin
                        phase_next = sldf_pkg::PH_HUNT;
                    end
                end
                sldf_pkg::PH_COLLECT:
                begin
                    bytes_seen_next = bytes_seen_reg + 5'd1;
                    if (bytes_seen_reg == 5'd2)
                    begin
                        type_byte_next   = rx_byte;
                        running_sum_next = running_sum_reg + rx_byte;
                    end
                    else if (pos_plus2 < len_ext)
                    begin
                        pay_wr.en        = 1'b1;
                        running_sum_next = running_sum_reg + rx_byte;
                    end
                    else if (pos_plus2 == len_ext)
                    begin
                        received_check_next = rx_byte;
                    end
                    else
                    begin
                        // end byte: hand the frame to the back end
                        push            = 1'b1;
                        phase_next      = sldf_pkg::PH_HUNT;
                        bytes_seen_next = '0;
                        if (!sum_ok)
                            push_desc.outcome = sldf_pkg::OC_BAD_SUM;
                        else if (!type_match)
                            push_desc.outcome = sldf_pkg::OC_MISMATCH;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == sldf_pkg::SYNC_BYTE) ?
                                 sldf_pkg::PH_SYNC : sldf_pkg::PH_HUNT;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/sldf_queue.sv =====
module sldf_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sldf_pkg::frame_desc_t push_desc,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output logic                  wr_ptr,
    output logic                  rd_ptr,
    output sldf_pkg::frame_desc_t head
);

    // two entries, each owning one payload bank
    sldf_pkg::frame_desc_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // descriptor storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    assign full   = count_reg[1];
    assign empty  = (count_reg == 2'd0);
    assign wr_ptr = wr_ptr_reg;
    assign rd_ptr = rd_ptr_reg;
    assign head   = entry_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/sldf_back.sv =====
module sldf_back
#(
    parameter int PAYLOAD_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sldf_pkg::pay_wr_t     pay_wr,
    input  logic                  empty,
    input  logic                  rd_ptr,
    input  sldf_pkg::frame_desc_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            outcome,
    output logic                  frame_kind,
    output logic [3:0]            byte_index,
    output logic [7:0]            payload_byte,
    output logic                  last
);

    localparam int MEM_DEPTH = 2 * PAYLOAD_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    // two payload banks
    logic [7:0] mem [MEM_DEPTH];

    logic [3:0]    idx_reg;
    logic          valid_reg;
    sldf_pkg::outcome_t outcome_reg;
    logic          kind_reg;
    logic [3:0]    index_reg;
    logic          last_reg;
    logic [7:0]    rd_data_reg;

    logic          load;
    logic          load_last;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = AW'(pay_wr.idx) + (pay_wr.bank ? AW'(PAYLOAD_DEPTH) : AW'(0));
    assign rd_addr = AW'(idx_reg) + (rd_ptr ? AW'(PAYLOAD_DEPTH) : AW'(0));

    // load the output register while a frame is queued and the register is free or being taken
    assign load      = !empty && (!valid_reg || out_ready);
    assign load_last = (head.outcome != sldf_pkg::OC_PAYLOAD) ||
                       (idx_reg == head.last_idx);
    assign pop       = load && load_last;

    // buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (pay_wr.en)
            mem[wr_addr] <= pay_wr.data;
        if (load)
            rd_data_reg <= mem[rd_addr];
    end

    // output word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            if (load)
                idx_reg <= load_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    // output word fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            outcome_reg <= head.outcome;
            kind_reg    <= head.kind;
            index_reg   <= (head.outcome == sldf_pkg::OC_PAYLOAD) ? idx_reg : 4'd0;
            last_reg    <= load_last;
        end
    end

    assign out_valid    = valid_reg;
    assign outcome      = outcome_reg;
    assign frame_kind   = kind_reg;
    assign byte_index   = index_reg;
    assign payload_byte = (outcome_reg == sldf_pkg::OC_PAYLOAD) ? rd_data_reg : 8'd0;
    assign last         = last_reg;

endmodule
